### rtl/kvt_pkg.sv
// Shared types and constants for the key/value table.
// No dependencies; every other file of the block uses this package.
package kvt_pkg;

    localparam int TYPE_W            = 2;
    localparam int KEY_W             = 32;
    localparam int VALUE_W           = 64;
    localparam int STATUS_W          = 3;
    localparam int COUNT_W           = 5;
    localparam int TABLE_ENTRIES_DEF = 16;

    // Request codes; the fourth code means nothing and reads as a miss.
    localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_DELETED   = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_TAIL   = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

endpackage

### rtl/kvt_req_if.sv
// Request channel of the key/value table: valid/ready plus the request word.
// Depends on kvt_pkg for field widths.
interface kvt_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [kvt_pkg::TYPE_W-1:0]           req_type;
    logic signed [kvt_pkg::KEY_W-1:0]     req_key;
    logic [kvt_pkg::VALUE_W-1:0]          req_value;

    modport source (output valid, output req_type, output req_key, output req_value,
                    input ready);
    modport sink   (input valid, input req_type, input req_key, input req_value,
                    output ready);
endinterface

### rtl/kvt_rsp_if.sv
// Response channel of the key/value table: valid/ready plus the result word.
// Depends on kvt_pkg for field widths.
interface kvt_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [kvt_pkg::STATUS_W-1:0]    status;
    logic [kvt_pkg::VALUE_W-1:0]     found_value;
    logic [kvt_pkg::COUNT_W-1:0]     entry_count;

    modport source (output valid, output status, output found_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found_value,
                    input entry_count, output ready);
endinterface

### rtl/kvt_entry_store.sv
// Entry storage: one memory of {valid, key} and one memory of values.
// One read and one write address per cycle, read data registered. Uses kvt_pkg.
module kvt_entry_store #(
    parameter int ENTRIES = kvt_pkg::TABLE_ENTRIES_DEF,
    parameter int IW      = $clog2(ENTRIES)
) (
    input  logic                          i_clk,
    input  logic [IW-1:0]                 i_rd_addr,
    output logic                          o_rd_valid,
    output logic [kvt_pkg::KEY_W-1:0]     o_rd_key,
    output logic [kvt_pkg::VALUE_W-1:0]   o_rd_value,
    input  logic [IW-1:0]                 i_wr_addr,
    input  logic                          i_key_we,
    input  logic                          i_wr_valid,
    input  logic [kvt_pkg::KEY_W-1:0]     i_wr_key,
    input  logic                          i_val_we,
    input  logic [kvt_pkg::VALUE_W-1:0]   i_wr_value
);
    import kvt_pkg::*;

    logic [KEY_W:0]     key_mem [ENTRIES];
    logic [VALUE_W-1:0] val_mem [ENTRIES];
    logic [KEY_W:0]     r_key_rd;
    logic [VALUE_W-1:0] r_val_rd;

    always_ff @(posedge i_clk) begin
        if (i_key_we) begin
            key_mem[i_wr_addr] <= {i_wr_valid, i_wr_key};
        end
        r_key_rd <= key_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_val_we) begin
            val_mem[i_wr_addr] <= i_wr_value;
        end
        r_val_rd <= val_mem[i_rd_addr];
    end

    assign o_rd_valid = r_key_rd[KEY_W];
    assign o_rd_key   = r_key_rd[KEY_W-1:0];
    assign o_rd_value = r_val_rd;

endmodule

### rtl/key_value_table.sv
// Associative key/value table of TABLE_ENTRIES slots. After reset the block
// clears the valid mark of every slot in the key memory and takes no
// request meanwhile. Each request then walks the whole key memory one entry
// per cycle through the single read port of the entry memories (S_SCAN), then
// passes S_TAIL and S_COMMIT, which waits until the output register is free.
// The result sits in an output register, and the next request is taken while
// it waits. Depends on kvt_pkg, kvt_req_if, kvt_rsp_if and kvt_entry_store.
module key_value_table #(
    parameter int TABLE_ENTRIES = kvt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kvt_req_if.sink    i_req,
    kvt_rsp_if.source  o_rsp
);
    import kvt_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    t_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_cmp_vld, n_cmp_vld;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;
    logic          r_hit_found, n_hit_found;
    logic          r_free_found, n_free_found;

    logic [IW-1:0]        r_cmp_idx, n_cmp_idx;
    logic [IW-1:0]        r_hit_idx, n_hit_idx;
    logic [IW-1:0]        r_free_idx, n_free_idx;
    logic [VALUE_W-1:0]   r_hit_value, n_hit_value;
    logic [TYPE_W-1:0]    r_type, n_type;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;
    logic [VALUE_W-1:0]   r_out_found, n_out_found;
    logic [COUNT_W-1:0]   r_out_count, n_out_count;

    logic                 rd_valid;
    logic [KEY_W-1:0]     rd_key;
    logic [VALUE_W-1:0]   rd_value;
    logic [IW-1:0]        wr_addr;
    logic                 key_we, val_we, wr_valid;
    logic                 commit_go;
    t_status              status;

    kvt_entry_store #(
        .ENTRIES (TABLE_ENTRIES),
        .IW      (IW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_addr  (r_idx),
        .o_rd_valid (rd_valid),
        .o_rd_key   (rd_key),
        .o_rd_value (rd_value),
        .i_wr_addr  (wr_addr),
        .i_key_we   (key_we),
        .i_wr_valid (wr_valid),
        .i_wr_key   (r_key),
        .i_val_we   (val_we),
        .i_wr_value (r_value)
    );

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_value = r_out_found;
    assign o_rsp.entry_count = r_out_count;

    assign commit_go = (r_state == S_COMMIT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_idx;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_hit_found  = r_hit_found;
        n_hit_idx    = r_hit_idx;
        n_hit_value  = r_hit_value;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_type       = r_type;
        n_key        = r_key;
        n_value      = r_value;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        wr_addr      = r_idx;
        key_we       = 1'b0;
        val_we       = 1'b0;
        wr_valid     = 1'b0;
        status       = ST_NOT_FOUND;

        // Compare stage: one entry's read data per cycle, arriving in the cycle after its address.
        if (r_cmp_vld) begin
            if (rd_valid && rd_key == r_key && !r_hit_found) begin
                n_hit_found = 1'b1;
                n_hit_idx   = r_cmp_idx;
                n_hit_value = rd_value;
            end
            if (!rd_valid && !r_free_found) begin
                n_free_found = 1'b1;
                n_free_idx   = r_cmp_idx;
            end
        end

        case (r_state)
            S_CLEAR: begin
                key_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_type       = i_req.req_type;
                    n_key        = i_req.req_key;
                    n_value      = i_req.req_value;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                    n_idx        = '0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cmp_vld = 1'b1;
                n_idx     = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (commit_go) begin
                    n_out_found = '0;
                    case (r_type)
                        REQ_INSERT: begin
                            if (r_hit_found) begin
                                wr_addr = r_hit_idx;
                                val_we  = 1'b1;
                                status  = ST_REPLACED;
                            end else if (r_free_found) begin
                                wr_addr  = r_free_idx;
                                key_we   = 1'b1;
                                val_we   = 1'b1;
                                wr_valid = 1'b1;
                                n_count  = r_count + 1'b1;
                                status   = ST_INSERTED;
                            end else begin
                                status = ST_FULL;
                            end
                        end
                        REQ_DELETE: begin
                            if (r_hit_found) begin
                                wr_addr = r_hit_idx;
                                key_we  = 1'b1;
                                n_count = r_count - 1'b1;
                                status  = ST_DELETED;
                            end
                        end
                        REQ_LOOKUP: begin
                            if (r_hit_found) begin
                                n_out_found = r_hit_value;
                                status      = ST_FOUND;
                            end
                        end
                        default: begin
                            status = ST_NOT_FOUND;
                        end
                    endcase
                    n_out_status = status;
                    n_out_count  = COUNT_W'(n_count);
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_cmp_vld    <= n_cmp_vld;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_hit_found  <= n_hit_found;
            r_free_found <= n_free_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx    <= n_cmp_idx;
        r_hit_idx    <= n_hit_idx;
        r_hit_value  <= n_hit_value;
        r_free_idx   <= n_free_idx;
        r_type       <= n_type;
        r_key        <= n_key;
        r_value      <= n_value;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

endmodule

### tb/tb.sv
// Self-checking testbench for key_value_table: a mirror of the table predicts
// every result and compares it with the response channel.
// Depends on kvt_pkg, kvt_req_if, kvt_rsp_if and the key_value_table RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kvt_pkg::*;

    localparam int                SLOTS      = TABLE_ENTRIES_DEF;
    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int                RANDOM_REQS = 1800;
    localparam int                QUIET_TAIL  = 200;
    localparam int                LONG_HOLD   = 300;
    localparam int                DRAIN_CYCLES = 40;
    localparam int                POOL_MAX    = 24;

    typedef struct {
        t_status             status;
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  count;
    } t_table_result;

    // Mirror of the table contents; predicts one result per accepted request.
    class kv_mirror;
        logic [KEY_W-1:0]   slot_key[SLOTS];
        logic [VALUE_W-1:0] slot_value[SLOTS];
        bit                 slot_used[SLOTS];
        int unsigned        used_count;
        t_table_result      expected_results[$];
        int                 errors;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            used_count = 0;
            errors     = 0;
        endfunction

        function void note_request(logic [TYPE_W-1:0] kind, logic [KEY_W-1:0] key,
                                   logic [VALUE_W-1:0] value);
            int            hit;
            int            empty;
            t_table_result r;
            hit   = -1;
            empty = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
                if (empty < 0 && !slot_used[i]) empty = i;
            end
            r.status = ST_NOT_FOUND;
            r.value  = '0;
            case (kind)
                REQ_INSERT: begin
                    if (hit >= 0) begin
                        slot_value[hit] = value;
                        r.status = ST_REPLACED;
                    end else if (empty < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        slot_key[empty]   = key;
                        slot_value[empty] = value;
                        slot_used[empty]  = 1'b1;
                        used_count++;
                        r.status = ST_INSERTED;
                    end
                end
                REQ_DELETE: begin
                    if (hit >= 0) begin
                        slot_used[hit] = 1'b0;
                        used_count--;
                        r.status = ST_DELETED;
                    end
                end
                REQ_LOOKUP: begin
                    if (hit >= 0) begin
                        r.value  = slot_value[hit];
                        r.status = ST_FOUND;
                    end
                end
                default: ;
            endcase
            r.count = used_count[COUNT_W-1:0];
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] value,
                                   logic [COUNT_W-1:0] count);
            t_table_result r;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status %0d value %h count %0d",
                         $time, status, value, count);
                errors++;
                return;
            end
            r = expected_results.pop_front();
            if (status !== r.status) begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, status);
                errors++;
            end
            if (value !== r.value) begin
                $display("%0t: found_value expected %h actual %h", $time, r.value, value);
                errors++;
            end
            if (count !== r.count) begin
                $display("%0t: entry_count expected %0d actual %0d", $time, r.count, count);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    bit   hold_wanted;

    kv_mirror mirror = new();

    kvt_req_if req_if();
    kvt_rsp_if rsp_if();

    key_value_table dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Offer one request word and hold it until the table takes it.
    task automatic offer_request(logic [TYPE_W-1:0] kind, logic [KEY_W-1:0] key,
                                 logic [VALUE_W-1:0] value);
        @(negedge clk);
        req_if.valid     <= 1'b1;
        req_if.req_type  <= kind;
        req_if.req_key   <= key;
        req_if.req_value <= value;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        mirror.note_request(kind, key, value);
    endtask

    task automatic pause_requests(int cycles);
        @(negedge clk);
        req_if.valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [TYPE_W-1:0] pick_kind(int ins, int del, int look);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins) return REQ_INSERT;
        if (r < ins + del) return REQ_DELETE;
        if (r < ins + del + look) return REQ_LOOKUP;
        return REQ_UNUSED;
    endfunction

    // Response side: random stall bursts, one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else if (hold_wanted) begin
                hold_wanted = 1'b0;
                rsp_if.ready <= 1'b0;
                stall_left = LONG_HOLD - 1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            mirror.check_result(rsp_if.status, rsp_if.found_value, rsp_if.entry_count);
    end

    initial begin
        #1ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [KEY_W-1:0] key_pool[POOL_MAX];
        logic [KEY_W-1:0] key;
        int               pool_size;
        int               ins, del, look;
        int               sent;

        rst_n            = 1'b0;
        quiet            = 1'b0;
        hold_wanted      = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_INSERT;
        req_if.req_key   = '0;
        req_if.req_value = '0;
        rsp_if.ready     = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Empty table, the meaningless request code, key and value extremes.
        offer_request(REQ_LOOKUP, 32'h0000_0000, '0);
        offer_request(REQ_DELETE, 32'h0000_0005, '0);
        offer_request(REQ_UNUSED, 32'hFFFF_FFFF, '1);
        offer_request(REQ_INSERT, 32'h8000_0000, '1);
        offer_request(REQ_INSERT, 32'h7FFF_FFFF, '0);
        offer_request(REQ_INSERT, 32'h0000_0000, 64'h0123_4567_89AB_CDEF);
        offer_request(REQ_INSERT, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001);
        offer_request(REQ_LOOKUP, 32'h8000_0000, '0);
        offer_request(REQ_INSERT, 32'h8000_0000, 64'h5555_5555_AAAA_AAAA);
        offer_request(REQ_LOOKUP, 32'h8000_0000, '1);
        offer_request(REQ_DELETE, 32'h8000_0000, '0);
        offer_request(REQ_DELETE, 32'h8000_0000, '0);
        // Refill from the lowest free slot up to a full table.
        for (int i = 0; i < 13; i++)
            offer_request(REQ_INSERT, 32'h1 << (i * 2), random_value());
        offer_request(REQ_INSERT, 32'h4000_0001, '1);
        offer_request(REQ_INSERT, 32'h7FFF_FFFF, 64'hDEAD_BEEF_0000_FFFF);
        offer_request(REQ_LOOKUP, 32'h7FFF_FFFF, '0);

        // Random phases: fill-heavy, drain-heavy and mixed traffic on a key pool.
        sent = 0;
        for (int phase = 0; phase < RANDOM_REQS / 150; phase++) begin
            pool_size = $urandom_range(12, POOL_MAX);
            for (int i = 0; i < pool_size; i++) begin
                case ($urandom_range(0, 11))
                    0:       key_pool[i] = 32'h8000_0000;
                    1:       key_pool[i] = 32'h7FFF_FFFF;
                    2:       key_pool[i] = 32'hFFFF_FFFF;
                    3:       key_pool[i] = 32'h0000_0000;
                    default: key_pool[i] = $urandom();
                endcase
            end
            case (phase % 3)
                0:       begin ins = 65; del = 15; look = 15; end
                1:       begin ins = 20; del = 50; look = 25; end
                default: begin ins = 40; del = 25; look = 30; end
            endcase
            for (int n = 0; n < 150; n++) begin
                if (sent == RANDOM_REQS / 3) hold_wanted = 1'b1;
                if (sent == RANDOM_REQS - QUIET_TAIL) quiet = 1'b1;
                if ($urandom_range(0, 9) == 0)
                    key = $urandom();
                else
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                offer_request(pick_kind(ins, del, look), key, random_value());
                sent++;
                // Keep some stretches free of gaps.
                if (!quiet && (phase % 4) != 3 && $urandom_range(0, 4) == 0)
                    pause_requests($urandom_range(1, 7));
            end
        end

        @(negedge clk);
        req_if.valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### filelist.f
rtl/kvt_pkg.sv
rtl/kvt_req_if.sv
rtl/kvt_rsp_if.sv
rtl/kvt_entry_store.sv
rtl/key_value_table.sv
tb/tb.sv
